/* src/md5_key_candidate_check_assert.svh */
// Assertion macros for the MD5 key candidate checker.
// Used by the port-level checker module; no other dependencies.
`ifndef MD5_KEY_CANDIDATE_CHECK_ASSERT_SVH
`define MD5_KEY_CANDIDATE_CHECK_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define MKC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define MKC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mkc_pkg.sv */
// Package for the MD5 key candidate checker: types, constants, MD5 round helpers.
// No dependencies.
package mkc_pkg;

  localparam int unsigned NumRounds = 64;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_MIXED  = 2'd1,
    MODE_DOUBLE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_SECRET  = 2'd1,
    REG_TGT_LO  = 2'd2,
    REG_TGT_HI  = 2'd3
  } reg_idx_e;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;
  localparam logic [31:0] PadWord = 32'h00000080;
  localparam logic [31:0] LenShort = 32'd32;
  localparam logic [31:0] LenLong = 32'd128;

  typedef logic [15:0][31:0] block_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md_state_t;

  function automatic logic [31:0] md_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md_r(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] md_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i + 1);
      2'd2: g = 4'(3 * i + 5);
      default: g = 4'(7 * i);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md_f(input logic [5:0] i, input md_state_t s);
    logic [31:0] f;
    case (i[5:4])
      2'd0: f = (s.b & s.c) | (~s.b & s.d);
      2'd1: f = (s.d & s.b) | (~s.d & s.c);
      2'd2: f = s.b ^ s.c ^ s.d;
      default: f = s.c ^ (s.b | ~s.d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] y;
    y = {x, x} << n;
    return y[63:32];
  endfunction

endpackage

/* src/md5_key_candidate_check.sv */
// MD5 key candidate checker: one trial value per cycle, pipelined throughput 1/cycle when not stalled.
// Register order: message build, 128 first-compression stages, second message build,
// 128 second-compression stages, then the compare into the output register.
// The whole pipeline stalls as one when the output register is full and not taken.
// Reset (rst_ni low, async) clears all valid bits and registers to mode 0, zero target.
module md5_key_candidate_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] trial_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [0] hit, [32:1] trial_echo, [39:33] zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  // Configuration registers
  logic [1:0]  mode_q;
  logic [31:0] secret_q;
  logic [63:0] tlo_q, thi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mkc_pkg::MODE_PLAIN;
      secret_q <= '0;
      tlo_q    <= '0;
      thi_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (mkc_pkg::reg_idx_e'(cfg_idx_i))
        mkc_pkg::REG_MODE:   mode_q   <= cfg_data_i[1:0];
        mkc_pkg::REG_SECRET: secret_q <= cfg_data_i[31:0];
        mkc_pkg::REG_TGT_LO: tlo_q    <= cfg_data_i;
        mkc_pkg::REG_TGT_HI: thi_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Output register with global enable
  logic        ov_q;
  logic        hit_q;
  logic [31:0] echo_q;
  logic        en;

  assign en = !ov_q || m_axis_tready;
  assign s_axis_tready = en;

  // Message build for the first compression
  logic            in_v;
  mkc_pkg::block_t blk1;
  logic [31:0]     t, s, m2, m3;

  assign in_v = s_axis_tvalid;
  assign t  = s_axis_tdata;
  assign s  = secret_q;
  assign m2 = t ^ (t >> 24) ^ (s << 8);
  assign m3 = s ^ (s >> 24) ^ (m2 << 8);

  always_comb begin
    blk1 = '0;
    blk1[0] = t;
    if (mode_q == mkc_pkg::MODE_PLAIN) begin
      blk1[1]  = mkc_pkg::PadWord;
      blk1[14] = mkc_pkg::LenShort;
    end else begin
      blk1[1]  = s;
      blk1[2]  = m2;
      blk1[3]  = m3;
      blk1[4]  = mkc_pkg::PadWord;
      blk1[14] = mkc_pkg::LenLong;
    end
  end

  logic               v1_q;
  mkc_pkg::block_t    b1_q;
  logic [34:0]        x1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_v;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q <= blk1;
      x1_q <= {mode_q, t, 1'b0};
    end
  end

  // First compression
  logic               c1v;
  mkc_pkg::md_state_t c1d;
  logic [34:0]        c1x;

  mkc_core u_core1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1_q), .blk_i(b1_q), .side_i(x1_q),
    .valid_o(c1v), .dig_o(c1d), .side_o(c1x)
  );

  // Second message: digest of the first, padded; the first digest is also registered for the delay line
  logic               v2_q;
  mkc_pkg::block_t    blk2;
  mkc_pkg::block_t    b2_q;
  logic [34:0]        x2_q;
  mkc_pkg::md_state_t d1_q;

  always_comb begin
    blk2     = '0;
    blk2[0]  = c1d.a;
    blk2[1]  = c1d.b;
    blk2[2]  = c1d.c;
    blk2[3]  = c1d.d;
    blk2[4]  = mkc_pkg::PadWord;
    blk2[14] = mkc_pkg::LenLong;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= c1v;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_q <= blk2;
      x2_q <= c1x;
      d1_q <= c1d;
    end
  end

  // Second compression; first digest delayed alongside through a matching line
  logic               c2v;
  mkc_pkg::md_state_t c2d;
  logic [34:0]        c2x;
  mkc_pkg::md_state_t dl_q [2 * mkc_pkg::NumRounds];

  mkc_core u_core2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q), .blk_i(b2_q), .side_i(x2_q),
    .valid_o(c2v), .dig_o(c2d), .side_o(c2x)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0] <= d1_q;
      for (int i = 1; i < 2 * mkc_pkg::NumRounds; i++) dl_q[i] <= dl_q[i-1];
    end
  end

  // Select digest by mode and compare with target
  mkc_pkg::md_state_t dsel;
  logic [1:0]         mode_p;
  logic               match;

  assign mode_p = c2x[34:33];
  assign dsel = (mode_p == mkc_pkg::MODE_DOUBLE) ? c2d : dl_q[2 * mkc_pkg::NumRounds - 1];
  assign match = (mode_p != mkc_pkg::MODE_NONE) && (dsel.a == tlo_q[31:0])
                 && (dsel.b == tlo_q[63:32]) && (dsel.c == thi_q[31:0])
                 && (dsel.d == thi_q[63:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= c2v;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= match;
      echo_q <= c2x[32:1];
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, echo_q, hit_q};

endmodule

/* src/mkc_core.sv */
// Pipelined MD5 compression of one block from the standard IV, two stages per round.
// Depends on mkc_pkg.
module mkc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  mkc_pkg::block_t    blk_i,
  input  logic [34:0]        side_i,
  output logic               valid_o,
  output mkc_pkg::md_state_t dig_o,
  output logic [34:0]        side_o
);

  localparam int unsigned NR = mkc_pkg::NumRounds;

  // Per round: stage A sums a + f + k + w, stage B rotates and adds to b.
  logic               va_q [NR];
  logic               vb_q [NR];
  mkc_pkg::md_state_t sa_q [NR];
  mkc_pkg::md_state_t sb_q [NR];
  logic [31:0]        sum_q [NR];
  mkc_pkg::block_t    wa_q [NR];
  mkc_pkg::block_t    wb_q [NR];
  logic [34:0]        xa_q [NR];
  logic [34:0]        xb_q [NR];

  for (genvar r = 0; r < NR; r++) begin : g_round
    localparam logic [5:0] Ri = 6'(r);
    logic               v_in;
    mkc_pkg::md_state_t s_in;
    mkc_pkg::block_t    w_in;
    logic [34:0]        x_in;
    mkc_pkg::md_state_t s_nx;

    if (r == 0) begin : g_first
      assign v_in = valid_i;
      assign s_in = '{a: mkc_pkg::IvA, b: mkc_pkg::IvB, c: mkc_pkg::IvC, d: mkc_pkg::IvD};
      assign w_in = blk_i;
      assign x_in = side_i;
    end else begin : g_next
      assign v_in = vb_q[r-1];
      assign s_in = sb_q[r-1];
      assign w_in = wb_q[r-1];
      assign x_in = xb_q[r-1];
    end

    always_comb begin
      s_nx.a = sa_q[r].d;
      s_nx.d = sa_q[r].c;
      s_nx.c = sa_q[r].b;
      s_nx.b = sa_q[r].b + mkc_pkg::rotl(sum_q[r], mkc_pkg::md_r(Ri));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q[r] <= 1'b0;
        vb_q[r] <= 1'b0;
      end else if (en_i) begin
        va_q[r] <= v_in;
        vb_q[r] <= va_q[r];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sa_q[r]  <= s_in;
        sum_q[r] <= s_in.a + mkc_pkg::md_f(Ri, s_in) + mkc_pkg::md_k(Ri)
                    + w_in[mkc_pkg::md_g(Ri)];
        wa_q[r]  <= w_in;
        xa_q[r]  <= x_in;
        sb_q[r]  <= s_nx;
        wb_q[r]  <= wa_q[r];
        xb_q[r]  <= xa_q[r];
      end
    end
  end

  // Feed-forward of the IV onto the last round's state.
  assign valid_o = vb_q[NR-1];
  assign side_o  = xb_q[NR-1];
  assign dig_o.a = mkc_pkg::IvA + sb_q[NR-1].a;
  assign dig_o.b = mkc_pkg::IvB + sb_q[NR-1].b;
  assign dig_o.c = mkc_pkg::IvC + sb_q[NR-1].c;
  assign dig_o.d = mkc_pkg::IvD + sb_q[NR-1].d;

endmodule

/* src/mkc_checker.sv */
// Port-level checker for the MD5 key candidate checker, bound to the top level.
// Depends on md5_key_candidate_check_assert.svh.
`include "md5_key_candidate_check_assert.svh"
module mkc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  `MKC_ASSERT_IMP(a_ready_when_free, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "stall without full output")
  `MKC_ASSERT_IMP(a_stall_only_full, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "stall source")
  `MKC_ASSERT_IMP(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[39:33] == 7'd0, "pad bits set")
  `MKC_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "beat dropped")
endmodule

bind md5_key_candidate_check mkc_checker u_mkc_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
